// ===== src/kgr_pkg.sv =====
`timescale 1ns / 1ps

package kgr_pkg;

    // Buffer geometry
    localparam int MAX_GROUP  = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CFG_W      = 5;
    localparam int IDX_W      = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CNT_W      = $clog2(MAX_GROUP + 1);
    localparam int BANKS      = 2;
    localparam int ADDR_W     = IDX_W + 1;

    // One finished group handed from the front to the back
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             rev;
        logic             last;
    } t_desc;

    // Buffer write request from the front
    typedef struct packed {
        logic                  en;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] data;
    } t_wr;

    // Bank handed back once its group has been read out
    typedef struct packed {
        logic en;
        logic bank;
    } t_rel;

    // Clamp the programmed group size to 1..MAX_GROUP
    function automatic logic [CNT_W-1:0] eff_size(input logic [CFG_W-1:0] gs);
        logic [CNT_W-1:0] k;
        if (gs == '0) begin
            k = CNT_W'(1);
        end else if (32'(gs) > MAX_GROUP) begin
            k = CNT_W'(MAX_GROUP);
        end else begin
            k = CNT_W'(gs);
        end
        return k;
    endfunction

endpackage

// ===== src/kgr_queue.sv =====
`timescale 1ns / 1ps

module kgr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kgr_pkg::t_desc i_desc,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output kgr_pkg::t_desc o_desc
);
    import kgr_pkg::*;

    t_desc      r_slot [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_cnt, n_cnt;

    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_desc  = r_slot[r_rptr];

    // Track occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    // Hold descriptors and advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
        if (i_push) begin
            r_slot[r_wptr] <= i_desc;
        end
    end

endmodule

// ===== src/kgr_front.sv =====
`timescale 1ns / 1ps

module kgr_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kgr_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [kgr_pkg::DATA_WIDTH-1:0] i_data,
    input  logic                           i_end,
    input  logic                           i_q_full,
    output logic                           o_push,
    output kgr_pkg::t_desc                 o_desc,
    output kgr_pkg::t_wr                   o_wr,
    input  kgr_pkg::t_rel                  i_rel
);
    import kgr_pkg::*;

    logic [CFG_W-1:0] r_gsize;
    logic [CNT_W-1:0] r_fill;
    logic             r_bank;
    logic [BANKS-1:0] r_busy, n_busy;
    logic [CNT_W-1:0] k, n_count;
    logic             accept, full_grp;

    // Take a request only into a bank that has been drained
    assign o_ready  = !r_busy[r_bank] && !i_q_full;
    assign accept   = i_valid && o_ready;
    assign k        = eff_size(r_gsize);
    assign n_count  = r_fill + CNT_W'(1);
    assign full_grp = (n_count >= k);

    // Store the value at the next free slot of the current bank
    assign o_wr.en   = accept;
    assign o_wr.addr = {r_bank, r_fill[IDX_W-1:0]};
    assign o_wr.data = i_data;

    // Classify: a full group drains reversed, a list end on a short group drains in order
    assign o_push      = accept && (full_grp || i_end);
    assign o_desc.bank  = r_bank;
    assign o_desc.count = n_count;
    assign o_desc.rev   = full_grp;
    assign o_desc.last  = i_end;

    // Mark banks waiting on the back, free them on release
    always_comb begin
        n_busy = r_busy;
        if (o_push) begin
            n_busy[r_bank] = 1'b1;
        end
        if (i_rel.en) begin
            n_busy[i_rel.bank] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gsize <= CFG_W'(2);
            r_fill  <= '0;
            r_bank  <= 1'b0;
            r_busy  <= '0;
        end else begin
            r_busy <= n_busy;
            if (i_cfg_we) begin
                r_gsize <= i_cfg_wdata;
            end
            if (o_push) begin
                r_fill <= '0;
                r_bank <= ~r_bank;
            end else if (accept) begin
                r_fill <= n_count;
            end
        end
    end

endmodule

// ===== src/kgr_back.sv =====
`timescale 1ns / 1ps

module kgr_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  kgr_pkg::t_wr                   i_wr,
    input  logic                           i_q_valid,
    input  kgr_pkg::t_desc                 i_desc,
    output logic                           o_pop,
    output kgr_pkg::t_rel                  o_rel,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [kgr_pkg::DATA_WIDTH-1:0] o_data,
    output logic                           o_last
);
    import kgr_pkg::*;

    logic [DATA_WIDTH-1:0] r_mem [BANKS*MAX_GROUP];
    logic [DATA_WIDTH-1:0] r_rd_data;
    logic                  r_rd_vld, r_rd_last;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      rev_idx;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  issue, final_rd, pop_out;
    logic [2:0]            credit_used;

    // Output skid FIFO
    logic [DATA_WIDTH-1:0] r_fifo_data [2];
    logic                  r_fifo_last [2];
    logic                  r_fwptr, r_frptr;
    logic [1:0]            r_fcnt, n_fcnt;

    assign o_valid = (r_fcnt != 2'd0);
    assign o_data  = r_fifo_data[r_frptr];
    assign o_last  = r_fifo_last[r_frptr];
    assign pop_out = o_valid && i_ready;

    // Issue a read only while the FIFO has room for everything in flight
    assign credit_used = 3'(r_fcnt) + 3'(r_rd_vld);
    assign issue       = i_q_valid && (credit_used < (3'd2 + 3'(pop_out)));
    assign final_rd    = (r_idx == i_desc.count - CNT_W'(1));
    assign rev_idx     = i_desc.count - CNT_W'(1) - r_idx;
    assign rd_addr     = {i_desc.bank,
                          i_desc.rev ? rev_idx[IDX_W-1:0] : r_idx[IDX_W-1:0]};

    // Drop the descriptor and hand the bank back on its final read
    assign o_pop     = issue && final_rd;
    assign o_rel.en   = o_pop;
    assign o_rel.bank = i_desc.bank;

    // Group buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (issue) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_last <= final_rd && i_desc.last;
        end
    end

    // Advance through the current group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            if (o_pop) begin
                r_idx <= '0;
            end else if (issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_comb begin
        n_fcnt = r_fcnt;
        if (r_rd_vld && !pop_out) begin
            n_fcnt = r_fcnt + 2'd1;
        end else if (!r_rd_vld && pop_out) begin
            n_fcnt = r_fcnt - 2'd1;
        end
    end

    // Hold results until the sink takes them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwptr <= 1'b0;
            r_frptr <= 1'b0;
            r_fcnt  <= 2'd0;
        end else begin
            r_fcnt <= n_fcnt;
            if (r_rd_vld) begin
                r_fwptr <= ~r_fwptr;
            end
            if (pop_out) begin
                r_frptr <= ~r_frptr;
            end
        end
        if (r_rd_vld) begin
            r_fifo_data[r_fwptr] <= r_rd_data;
            r_fifo_last[r_fwptr] <= r_rd_last;
        end
    end

    a_fifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld && !pop_out |-> r_fcnt != 2'd2)
        else $error("output FIFO overflow");

    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> r_idx < i_desc.count)
        else $error("read index beyond group");

    a_idx_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_valid |-> r_idx == '0)
        else $error("read index not cleared between groups");

    a_rel_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rel.en |=> r_rd_vld)
        else $error("bank released without its final read");

endmodule

// ===== src/k_group_reverser.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Fields (lowest bit up)
// s_axis    in   tdata: item_value[31:0]; tlast: list_end
// m_axis    out  tdata: out_value[31:0];  tlast: out_last
// cfg       in   i_cfg_wdata: group_size[4:0], written when i_cfg_we is high
//
// Input takes one value per cycle into one of two group banks.
// A group of K values drains at one value per cycle, each value passing the bank
// read register and skid FIFO; one bank fills while the other drains.
// Input stalls only while both banks hold groups waiting to drain.
// Reset is synchronous, active low; group_size returns to 2.
// Output stalls back up through a two-entry skid FIFO to the bank reads.

module k_group_reverser (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [kgr_pkg::CFG_W-1:0]           i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic signed [kgr_pkg::DATA_WIDTH-1:0] s_axis_tdata,  // item_value
    input  logic                                s_axis_tlast,    // list_end
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic signed [kgr_pkg::DATA_WIDTH-1:0] m_axis_tdata,  // out_value
    output logic                                m_axis_tlast     // out_last
);
    import kgr_pkg::*;

    t_desc                 push_desc, head_desc;
    t_wr                   wr;
    t_rel                  rel;
    logic                  push, pop, q_valid, q_full;
    logic [DATA_WIDTH-1:0] out_data;

    kgr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (DATA_WIDTH'(s_axis_tdata)),
        .i_end       (s_axis_tlast),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_desc      (push_desc),
        .o_wr        (wr),
        .i_rel       (rel)
    );

    kgr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_desc  (head_desc)
    );

    kgr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_q_valid (q_valid),
        .i_desc    (head_desc),
        .o_pop     (pop),
        .o_rel     (rel),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (out_data),
        .o_last    (m_axis_tlast)
    );

    assign m_axis_tdata = $signed(out_data);

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import kgr_pkg::MAX_GROUP;
    import kgr_pkg::DATA_WIDTH;
    import kgr_pkg::CFG_W;

    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 150;
    localparam int DRAIN_CYCLES  = 20;
    localparam int STALL_LIMIT   = 1000;
    localparam int RAND_ITEMS    = 330;
    localparam int NDIR          = 26;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    // One directed step: either a size write or one request, with up to two
    // hand-typed outputs where the answer is obvious
    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_W-1:0]      size;
        logic [DATA_WIDTH-1:0] value;
        logic                  last;
        logic                  typed;
        logic [1:0]            n_typed;
        logic [DATA_WIDTH-1:0] v0;
        logic                  l0;
        logic [DATA_WIDTH-1:0] v1;
        logic                  l1;
    } stim_row_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] value;
        logic                  last;
    } out_item_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_W-1:0]      i_cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [DATA_WIDTH-1:0] s_axis_tdata;   // item_value
    logic                  s_axis_tlast;   // list_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [DATA_WIDTH-1:0] m_axis_tdata;   // out_value
    logic                  m_axis_tlast;   // out_last

    // Own copy of the block's state
    logic [CFG_W-1:0]      cur_size;
    logic [DATA_WIDTH-1:0] held_vals [MAX_GROUP];
    int                    held_n;

    out_item_t awaited_out [$];
    out_item_t head;
    stim_row_t dir_tab [NDIR];
    stim_row_t cur_row;

    int fault_count = 0;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit idle_on = 1'b1;
    bit hold_pending = 1'b0;

    k_group_reverser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Clamp a programmed size to the usable group length
    function automatic int group_len(input logic [CFG_W-1:0] gs);
        if (gs == '0) begin
            return 1;
        end else if (int'(gs) > MAX_GROUP) begin
            return MAX_GROUP;
        end
        return int'(gs);
    endfunction

    // Favour the corners of the value range now and then
    function automatic logic [DATA_WIDTH-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Advance the group state by one request; queue the outputs it releases
    task automatic reorder_item(input logic [DATA_WIDTH-1:0] v, input logic e,
                                input bit push);
        int k;
        int n;
        k = group_len(cur_size);
        if (held_n < MAX_GROUP) begin
            held_vals[held_n] = v;
            held_n++;
        end
        n = held_n;
        if (n >= k) begin
            for (int i = 0; i < n; i++) begin
                if (push) awaited_out.push_back('{held_vals[n-1-i], e && (i == n - 1)});
            end
            held_n = 0;
        end else if (e) begin
            for (int i = 0; i < n; i++) begin
                if (push) awaited_out.push_back('{held_vals[i], i == n - 1});
            end
            held_n = 0;
        end
    endtask

    // Offer one request from a falling edge and hold it until taken
    task automatic send_item(input logic [DATA_WIDTH-1:0] v, input logic e,
                             input bit push);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= e;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        reorder_item(v, e, push);
        @(negedge i_clk);
    endtask

    // Write the group size once every due output has drained
    task automatic write_size(input logic [CFG_W-1:0] gs);
        s_axis_tvalid <= 1'b0;
        while (awaited_out.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= gs;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cur_size = gs;
    endtask

    // Receiver: random back-pressure bursts, plus one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else if (hold_pending) begin
                hold_pending = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each output against the oldest one due
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_out.size() == 0) begin
                $display("%0t: output %h last %0b with nothing due", $time,
                         m_axis_tdata, m_axis_tlast);
                fault_count++;
            end else begin
                head = awaited_out.pop_front();
                if (m_axis_tdata !== head.value || m_axis_tlast !== head.last) begin
                    $display("%0t: expected value %h last %0b, got value %h last %0b",
                             $time, head.value, head.last, m_axis_tdata, m_axis_tlast);
                    fault_count++;
                end
            end
        end
    end

    // Stop the run when neither side moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d outputs still due",
                         $time, quiet_cycles, awaited_out.size());
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int sent;
        int k;
        int len;
        int nl;
        int phase;
        bit cut;
        bit hold_done;
        logic [CFG_W-1:0] gs;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cur_size      = 5'd2;
        held_n        = 0;
        for (int i = 0; i < MAX_GROUP; i++) held_vals[i] = '0;

        // Reset size is two: pairs swap, a short tail comes out as it is
        dir_tab[0]  = '{ROW_ITEM, 0, 32'h7FFFFFFF, 0, 1, 0, 0, 0, 0, 0};
        dir_tab[1]  = '{ROW_ITEM, 0, 32'h80000000, 0, 1, 2, 32'h80000000, 0,
                        32'h7FFFFFFF, 0};
        dir_tab[2]  = '{ROW_ITEM, 0, 32'hFFFFFFFF, 1, 1, 1, 32'hFFFFFFFF, 1, 0, 0};
        dir_tab[3]  = '{ROW_ITEM, 0, 32'h00000000, 1, 1, 1, 32'h00000000, 1, 0, 0};
        dir_tab[4]  = '{ROW_ITEM, 0, 32'h00000001, 0, 1, 0, 0, 0, 0, 0};
        // List end on a complete group: the oldest value carries the mark
        dir_tab[5]  = '{ROW_ITEM, 0, 32'h00000002, 1, 1, 2, 32'h00000002, 0,
                        32'h00000001, 1};
        // Size one passes straight through
        dir_tab[6]  = '{ROW_CFG, 1, 0, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[7]  = '{ROW_ITEM, 0, 32'h55555555, 0, 1, 1, 32'h55555555, 0, 0, 0};
        dir_tab[8]  = '{ROW_ITEM, 0, 32'hAAAAAAAA, 1, 1, 1, 32'hAAAAAAAA, 1, 0, 0};
        // Size zero behaves as one
        dir_tab[9]  = '{ROW_CFG, 0, 0, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[10] = '{ROW_ITEM, 0, 32'h12345678, 0, 1, 1, 32'h12345678, 0, 0, 0};
        dir_tab[11] = '{ROW_ITEM, 0, 32'hFFFFFFFB, 1, 1, 1, 32'hFFFFFFFB, 1, 0, 0};
        // Oversized setting saturates; a short list leaves in arrival order
        dir_tab[12] = '{ROW_CFG, 31, 0, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[13] = '{ROW_ITEM, 0, 32'hDEADBEEF, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[14] = '{ROW_ITEM, 0, 32'h00000010, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[15] = '{ROW_ITEM, 0, 32'h80000001, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[16] = '{ROW_ITEM, 0, 32'h7FFFFFFE, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[17] = '{ROW_ITEM, 0, 32'h0000FFFF, 1, 0, 0, 0, 0, 0, 0};
        // Shrink the size under three held values: all four leave reversed
        dir_tab[18] = '{ROW_CFG, 5, 0, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[19] = '{ROW_ITEM, 0, 32'h11111111, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[20] = '{ROW_ITEM, 0, 32'h22222222, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[21] = '{ROW_ITEM, 0, 32'h33333333, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[22] = '{ROW_CFG, 2, 0, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[23] = '{ROW_ITEM, 0, 32'h44444444, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[24] = '{ROW_CFG, 17, 0, 0, 0, 0, 0, 0, 0, 0};
        dir_tab[25] = '{ROW_ITEM, 0, 32'h00000001, 1, 0, 0, 0, 0, 0, 0};

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        for (int r = 0; r < NDIR; r++) begin
            cur_row = dir_tab[r];
            if (cur_row.kind == ROW_CFG) begin
                write_size(cur_row.size);
            end else begin
                if (cur_row.typed) begin
                    if (cur_row.n_typed > 0) awaited_out.push_back('{cur_row.v0, cur_row.l0});
                    if (cur_row.n_typed > 1) awaited_out.push_back('{cur_row.v1, cur_row.l1});
                end
                send_item(cur_row.value, cur_row.last, !cur_row.typed);
            end
        end

        // Random phases: a few lists per size, sometimes one left open
        sent = 0;
        phase = 0;
        hold_done = 1'b0;
        while (sent < RAND_ITEMS) begin
            case (phase)
                0: gs = 5'd16;
                1: gs = 5'd31;
                2: gs = 5'd1;
                3: gs = 5'd0;
                4: gs = 5'd17;
                default: gs = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(0, 31))
                                                           : CFG_W'($urandom_range(1, 6));
            endcase
            write_size(gs);
            k = group_len(gs);
            nl = $urandom_range(1, 3);
            for (int l = 0; l < nl; l++) begin
                len = $urandom_range(1, 3 * k + 1);
                cut = (l == nl - 1) && ($urandom_range(0, 2) == 0);
                for (int i = 0; i < len; i++) begin
                    send_item(rand_value(), (i == len - 1) && !cut, 1'b1);
                end
                sent += len;
            end
            // Hold the receiver off while a long list keeps arriving
            if (!hold_done && sent >= 120) begin
                hold_done = 1'b1;
                hold_pending = 1'b1;
                for (int i = 0; i < 48; i++) begin
                    send_item(rand_value(), i == 47, 1'b1);
                end
                sent += 48;
            end
            if (sent >= RAND_ITEMS - 60) idle_on = 1'b0;
            phase++;
        end

        // Drain and let the block settle
        s_axis_tvalid <= 1'b0;
        while (awaited_out.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fault_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
